// File: sv/egcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared sizes and word types for the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int MAX_STEPS  = 48;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int ADDR_W     = $clog2(MAX_STEPS);
	localparam int BIT_W      = $clog2(DATA_WIDTH);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] operand_a;
		logic signed [DATA_WIDTH-1:0] operand_b;
	} egcd_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] gcd_value;
		logic signed [DATA_WIDTH-1:0] coef_x;
		logic signed [DATA_WIDTH-1:0] coef_y;
		logic                         undefined;
	} egcd_out_t;
endpackage

// File: sv/egcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module egcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: sv/extended_gcd_bezout_top.sv
`timescale 1ns / 1ps
// Each Euclid step runs a check, then a bit-serial restoring divider, a fixup and a
// quotient store; then a final check and, for each step of back-substitution, a RAM
// read, a multiply and an update. With b zero the result comes from the first check;
// with both operands zero, done is raised straight from idle.
// One word in flight; busy is high while it runs. done is a one-cycle strobe, no stall.
// Reset clears the sequencer and done; quotient RAM contents are don't-care.
// ----------------------------------------------------------------------------
// extended_gcd_bezout_top
// Extended Euclid (Euclidean division) with Bezout coefficients.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_top
	import egcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  egcd_in_t  operands,
	output logic      done,
	output egcd_out_t result
);
	localparam int W = DATA_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_DIV, ST_FIX, ST_STORE, ST_BRD, ST_BMUL, ST_BUPD
	} state_t;

	state_t            state_q;
	logic [W-1:0]      a_q, b_q, x_q, y_q, prod_q;
	logic [W-1:0]      mb_q, dvd_q, quo_q;
	logic [W:0]        rem_q;
	logic              an_q, bn_q;
	logic [BIT_W-1:0]  bit_q;
	logic [STEP_W-1:0] n_q;
	logic              done_q;
	egcd_out_t         result_q;

	logic [W:0]        trial;
	logic              fit;
	logic [W-1:0]      q_signed;
	logic [W-1:0]      ram_rdata;
	logic [STEP_W-1:0] n_dec;

	assign trial    = {rem_q[W-1:0], dvd_q[W-1]};
	assign fit      = trial >= {1'b0, mb_q};
	assign q_signed = (an_q ^ bn_q) ? (~quo_q + 1'b1) : quo_q;
	assign n_dec    = n_q - 1'b1;

	egcd_ram #(.WIDTH(W), .DEPTH(MAX_STEPS)) u_quot (
		.clk     (clk),
		.wr_en   (state_q == ST_STORE),
		.wr_addr (n_q[ADDR_W-1:0]),
		.wr_data (q_signed),
		.rd_addr (n_dec[ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q <= operands.operand_a;
						b_q <= operands.operand_b;
						x_q <= W'(1);
						y_q <= '0;
						n_q <= '0;
						if (operands.operand_a == '0 && operands.operand_b == '0) begin
							result_q <= '{gcd_value: '0, coef_x: '0, coef_y: '0,
								undefined: 1'b1};
							done_q   <= 1'b1;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (b_q == '0 || n_q == STEP_W'(MAX_STEPS)) begin
						if (n_q == '0) begin
							result_q <= '{gcd_value: a_q, coef_x: x_q, coef_y: y_q,
								undefined: 1'b0};
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_BRD;
						end
					end else begin
						an_q    <= a_q[W-1];
						bn_q    <= b_q[W-1];
						dvd_q   <= a_q[W-1] ? (~a_q + 1'b1) : a_q;
						mb_q    <= b_q[W-1] ? (~b_q + 1'b1) : b_q;
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= BIT_W'(W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle
					rem_q   <= fit ? (trial - {1'b0, mb_q}) : trial;
					quo_q   <= {quo_q[W-2:0], fit};
					dvd_q   <= {dvd_q[W-2:0], 1'b0};
					bit_q   <= bit_q - 1'b1;
					if (bit_q == '0) state_q <= ST_FIX;
				end
				ST_FIX: begin
					// negative dividend: round quotient away, keep remainder >= 0
					if (an_q && rem_q != '0) begin
						quo_q <= quo_q + 1'b1;
						rem_q <= {1'b0, mb_q} - rem_q;
					end
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					a_q     <= b_q;
					b_q     <= rem_q[W-1:0];
					n_q     <= n_q + 1'b1;
					state_q <= ST_CHECK;
				end
				ST_BRD: begin
					state_q <= ST_BMUL;
				end
				ST_BMUL: begin
					prod_q  <= W'(ram_rdata * y_q);
					state_q <= ST_BUPD;
				end
				ST_BUPD: begin
					x_q <= y_q;
					y_q <= x_q - prod_q;
					n_q <= n_dec;
					if (n_q == STEP_W'(1)) begin
						result_q <= '{gcd_value: a_q, coef_x: y_q, coef_y: x_q - prod_q,
							undefined: 1'b0};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_BRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;
endmodule
